[hw/rtl/vertex_perspective_projection_core_defines.svh]
// Assertion macros for the vertex projection core.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef VERTEX_PERSPECTIVE_PROJECTION_CORE_DEFINES_SVH
`define VERTEX_PERSPECTIVE_PROJECTION_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VPP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/vpp_pkg.sv]
// Shared types, constants and helpers for the vertex projection core.
// No dependencies.
`default_nettype none
package vpp_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int NUM_COEFFS  = 12;
    localparam int WIDE_W      = 2 * COORD_WIDTH;
    localparam int SUM_W       = 2 * COORD_WIDTH + 2;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    localparam logic [1:0] REG_CENTER_X    = 2'd0;
    localparam logic [1:0] REG_CENTER_Y    = 2'd1;
    localparam logic [1:0] REG_SCREEN_GAIN = 2'd2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [WIDE_W-1:0]      t_wide;
    typedef logic signed [SUM_W-1:0]       t_sum;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic       cmd;
        logic [3:0] coeff_index;
        t_coord     coeff_value;
        t_coord     point_x;
        t_coord     point_y;
        t_coord     point_z;
    } t_in_item;

    typedef struct packed {
        t_coord screen_x;
        t_coord screen_y;
        logic   depth_zero;
    } t_out_item;

    typedef struct packed {
        t_coord vx;
        t_coord vy;
        t_coord vz;
    } t_view;

    typedef struct packed {
        t_coord center_x;
        t_coord center_y;
        t_coord screen_gain;
    } t_cfg;

    function automatic t_coord sat_coord(t_sum v);
        t_coord r;
        if (v > t_sum'(COORD_MAX)) begin
            r = COORD_MAX;
        end else if (v < t_sum'(COORD_MIN)) begin
            r = COORD_MIN;
        end else begin
            r = v[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/vertex_perspective_projection_core.sv]
// Vertex perspective projection core, Q16.16: affine view transform, then
// screen = center +/- gain*V/Z with saturation and a zero-depth flag.
// Throughput: one item per cycle while the output is not stalled. Most of the
// pipeline is the 64-stage pipelined divider (one quotient bit per stage).
// Load items finish in the front end and give no result.
// Reset (synchronous, active low) restores the identity matrix, gain 1.0, center 0.
`default_nettype none
`include "vertex_perspective_projection_core_defines.svh"
module vertex_perspective_projection_core
    import vpp_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_item,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_result,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire t_coord     i_cfg_data
);

    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    t_cfg               r_cfg;
    logic               w_push_valid;
    logic               w_push_ready;
    t_view              w_push_data;
    logic               w_pop_valid;
    logic               w_pop;
    t_view              w_pop_data;
    logic [LEVEL_W-1:0] w_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x    <= '0;
            r_cfg.center_y    <= '0;
            r_cfg.screen_gain <= t_coord'(1) <<< FRAC_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CENTER_X:    r_cfg.center_x    <= i_cfg_data;
                REG_CENTER_Y:    r_cfg.center_y    <= i_cfg_data;
                REG_SCREEN_GAIN: r_cfg.screen_gain <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    vpp_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_item       (i_item),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    vpp_fifo #(
        .DEPTH   (QUEUE_DEPTH),
        .LEVEL_W (LEVEL_W)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop),
        .o_pop_data   (w_pop_data),
        .o_level      (w_level)
    );

    vpp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (w_pop_valid),
        .o_pop       (w_pop),
        .i_pop_data  (w_pop_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    `VPP_ASSERT_SAME(a_stall_only_when_full, !o_in_ready, !w_push_ready, "front stalled with room in queue")
    `VPP_ASSERT_NEXT(a_level_step, 1'b1, w_level <= $past(w_level) + 1'b1, "queue level jumped")
    `VPP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_result), "result word changed while stalled")

endmodule
`default_nettype wire

[hw/rtl/vpp_front.sv]
// Front end: accepts items, keeps the affine matrix, computes view coordinates.
// Depends on vpp_pkg.
`default_nettype none
module vpp_front
    import vpp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_item,
    output logic          o_push_valid,
    input  wire logic     i_push_ready,
    output t_view         o_push_data
);

    localparam t_coord ONE = t_coord'(1) <<< FRAC_BITS;

    t_coord r_coeff [0:NUM_COEFFS-1];
    logic   r_s1_valid;
    t_wide  r_prod  [0:8];
    t_coord r_trans [0:2];
    logic   w_accept;
    logic   w_s1_ready;
    t_coord w_pt    [0:2];
    t_sum   w_sum   [0:2];
    t_coord w_view  [0:2];

    assign w_s1_ready = !r_s1_valid || i_push_ready;
    assign o_in_ready = w_s1_ready;
    assign w_accept   = i_in_valid && w_s1_ready;

    assign w_pt[0] = i_item.point_x;
    assign w_pt[1] = i_item.point_y;
    assign w_pt[2] = i_item.point_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEFFS; i++) begin
                r_coeff[i] <= (i == 0 || i == 5 || i == 10) ? ONE : '0;
            end
            r_s1_valid <= 1'b0;
        end else begin
            if (w_accept && i_item.cmd == CMD_LOAD &&
                i_item.coeff_index < 4'(NUM_COEFFS)) begin
                r_coeff[i_item.coeff_index] <= i_item.coeff_value;
            end
            if (w_s1_ready) begin
                r_s1_valid <= w_accept && i_item.cmd == CMD_PROJECT;
            end
        end
    end

    // Products and translation are captured together so later loads cannot leak in
    always_ff @(posedge i_clk) begin
        if (w_accept && i_item.cmd == CMD_PROJECT) begin
            for (int r = 0; r < 3; r++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[r*3+j] <= t_wide'(r_coeff[r*4+j]) * t_wide'(w_pt[j]);
                end
                r_trans[r] <= r_coeff[r*4+3];
            end
        end
    end

    // Floor shift of each product, add translation, saturate
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = t_sum'(r_prod[r*3]   >>> FRAC_BITS)
                     + t_sum'(r_prod[r*3+1] >>> FRAC_BITS)
                     + t_sum'(r_prod[r*3+2] >>> FRAC_BITS)
                     + t_sum'(r_trans[r]);
            w_view[r] = sat_coord(w_sum[r]);
        end
    end

    assign o_push_valid   = r_s1_valid;
    assign o_push_data.vx = w_view[0];
    assign o_push_data.vy = w_view[1];
    assign o_push_data.vz = w_view[2];

endmodule
`default_nettype wire

[hw/rtl/vpp_fifo.sv]
// Short queue of view coordinates between front and back ends.
// Depends on vpp_pkg.
`default_nettype none
module vpp_fifo
    import vpp_pkg::*;
#(
    parameter int DEPTH   = 4,
    parameter int LEVEL_W = $clog2(DEPTH + 1)
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    input  wire t_view i_push_data,
    output logic       o_pop_valid,
    input  wire logic  i_pop,
    output t_view      o_pop_data,
    output logic [LEVEL_W-1:0] o_level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_view              r_mem [0:DEPTH-1];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [LEVEL_W-1:0] r_level;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = r_level < LEVEL_W'(DEPTH);
    assign o_pop_valid  = r_level != '0;
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign o_level      = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_level <= r_level + 1'b1;
            end else if (w_pop && !w_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/vpp_back.sv]
// Back end: gain multiply, pipelined restoring divide by depth, center offset.
// Depends on vpp_pkg.
`default_nettype none
module vpp_back
    import vpp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_pop_valid,
    output logic       o_pop,
    input  wire t_view i_pop_data,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_out_item  o_result
);

    localparam int CW    = COORD_WIDTH;
    localparam int NSTEP = 2 * CW;

    typedef struct packed {
        logic [CW:0]     rem;
        logic [NSTEP-1:0] nq;
    } t_div_lane;

    typedef struct packed {
        logic          zero;
        logic          qneg_x;
        logic          qneg_y;
        logic          nneg_x;
        logic          nneg_y;
        logic          nz_x;
        logic          nz_y;
        logic [CW-1:0] dvs;
        t_div_lane     lx;
        t_div_lane     ly;
    } t_div_stage;

    function automatic t_div_lane div_step(t_div_lane l, logic [CW-1:0] d);
        logic [CW+1:0] sh;
        logic [CW+1:0] diff;
        t_div_lane     o;
        sh    = {l.rem, l.nq[NSTEP-1]};
        diff  = sh - {2'b00, d};
        o.nq  = {l.nq[NSTEP-2:0], ~diff[CW+1]};
        o.rem = diff[CW+1] ? sh[CW:0] : diff[CW:0];
        return o;
    endfunction

    // One quotient bit per stage for both lanes
    function automatic t_div_stage div_stage(t_div_stage st);
        t_div_stage o;
        o    = st;
        o.lx = div_step(st.lx, st.dvs);
        o.ly = div_step(st.ly, st.dvs);
        return o;
    endfunction

    function automatic t_sum signed_quo(logic [NSTEP-1:0] mag, logic qneg, logic zero,
                                        logic nneg, logic nz);
        t_sum q;
        if (zero) begin
            q = nneg ? t_sum'(COORD_MIN) : (nz ? t_sum'(COORD_MAX) : '0);
        end else begin
            q = qneg ? -t_sum'({2'b00, mag}) : t_sum'({2'b00, mag});
        end
        return q;
    endfunction

    logic       w_adv;
    logic       r_m_valid;
    t_wide      r_m_nx;
    t_wide      r_m_ny;
    t_coord     r_m_vz;
    logic       r_dv_valid [0:NSTEP];
    t_div_stage r_dv       [0:NSTEP];
    t_div_stage w_entry;
    logic       r_out_valid;
    t_out_item  r_out;
    t_div_stage w_last;
    t_sum       w_sx;
    t_sum       w_sy;

    // Whole back end advances together; bubbles ride along
    assign w_adv = !r_out_valid || i_out_ready;
    assign o_pop = w_adv && i_pop_valid;

    always_comb begin
        w_entry.zero   = r_m_vz == '0;
        w_entry.qneg_x = r_m_nx[NSTEP-1] ^ r_m_vz[CW-1];
        w_entry.qneg_y = r_m_ny[NSTEP-1] ^ r_m_vz[CW-1];
        w_entry.nneg_x = r_m_nx[NSTEP-1];
        w_entry.nneg_y = r_m_ny[NSTEP-1];
        w_entry.nz_x   = r_m_nx != '0;
        w_entry.nz_y   = r_m_ny != '0;
        w_entry.dvs    = r_m_vz[CW-1] ? CW'(-r_m_vz) : CW'(r_m_vz);
        w_entry.lx.rem = '0;
        w_entry.ly.rem = '0;
        w_entry.lx.nq  = r_m_nx[NSTEP-1] ? NSTEP'(-r_m_nx) : NSTEP'(r_m_nx);
        w_entry.ly.nq  = r_m_ny[NSTEP-1] ? NSTEP'(-r_m_ny) : NSTEP'(r_m_ny);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s <= NSTEP; s++) begin
                r_dv_valid[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_m_valid     <= i_pop_valid;
            r_dv_valid[0] <= r_m_valid;
            for (int s = 1; s <= NSTEP; s++) begin
                r_dv_valid[s] <= r_dv_valid[s-1];
            end
            r_out_valid <= r_dv_valid[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_nx <= t_wide'(i_cfg.screen_gain) * t_wide'(i_pop_data.vx);
            r_m_ny <= t_wide'(i_cfg.screen_gain) * t_wide'(i_pop_data.vy);
            r_m_vz <= i_pop_data.vz;
            r_dv[0] <= w_entry;
            for (int s = 1; s <= NSTEP; s++) begin
                r_dv[s] <= div_stage(r_dv[s-1]);
            end
        end
    end

    assign w_last = r_dv[NSTEP];
    assign w_sx = t_sum'(i_cfg.center_x)
                + signed_quo(w_last.lx.nq, w_last.qneg_x, w_last.zero,
                             w_last.nneg_x, w_last.nz_x);
    assign w_sy = t_sum'(i_cfg.center_y)
                - signed_quo(w_last.ly.nq, w_last.qneg_y, w_last.zero,
                             w_last.nneg_y, w_last.nz_y);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.screen_x   <= sat_coord(w_sx);
            r_out.screen_y   <= sat_coord(w_sy);
            r_out.depth_zero <= w_last.zero;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule
`default_nettype wire

[tb/tb_vertex_perspective_projection_core.sv]
// Self-checking testbench for vertex_perspective_projection_core.
// Needs vpp_pkg; predicts projected screen words from a local matrix and config copy.
`default_nettype none
module tb_vertex_perspective_projection_core;
    import vpp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int LATENCY = 69;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   i_item = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_result;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    t_coord     i_cfg_data = '0;

    vertex_perspective_projection_core dut (.*);

    always #1 i_clk = ~i_clk;

    // Predictor state
    logic signed [63:0] mat [NUM_COEFFS];
    logic signed [63:0] cx, cy, gain;

    t_in_item  pending_words [$];
    t_out_item expected_screen [$];
    int errors = 0;
    int n_points = 0, n_loads = 0, n_checked = 0, n_zero = 0;
    int send_idle = 0, recv_idle = 0;
    bit stall_active = 0;
    bit stall_go = 0;
    bit run_done = 0;
    logic took_in = 1'b0;

    function automatic logic signed [63:0] sat64(logic signed [65:0] v);
        if (v > 66'sd2147483647) return 64'sd2147483647;
        if (v < -66'sd2147483648) return -64'sd2147483648;
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] view_row(int row, logic signed [63:0] px,
            logic signed [63:0] py, logic signed [63:0] pz);
        logic signed [65:0] s;
        s = 66'(mat[row*4] * px >>> FRAC) + 66'(mat[row*4+1] * py >>> FRAC)
          + 66'(mat[row*4+2] * pz >>> FRAC) + 66'(mat[row*4+3]);
        return sat64(s);
    endfunction

    function automatic logic signed [63:0] persp_div(logic signed [63:0] num,
            logic signed [63:0] den);
        if (den == 0) return (num > 0) ? 64'sd2147483647 :
                             (num < 0) ? -64'sd2147483648 : 64'sd0;
        return num / den;
    endfunction

    function automatic void project_word(t_in_item w);
        logic signed [63:0] vx, vy, vz;
        t_out_item r;
        if (w.cmd == CMD_LOAD) begin
            if (w.coeff_index < NUM_COEFFS) mat[w.coeff_index] = 64'(w.coeff_value);
            return;
        end
        vx = view_row(0, 64'(w.point_x), 64'(w.point_y), 64'(w.point_z));
        vy = view_row(1, 64'(w.point_x), 64'(w.point_y), 64'(w.point_z));
        vz = view_row(2, 64'(w.point_x), 64'(w.point_y), 64'(w.point_z));
        r.screen_x = t_coord'(sat64(66'(cx) + 66'(persp_div(gain * vx, vz))));
        r.screen_y = t_coord'(sat64(66'(cy) - 66'(persp_div(gain * vy, vz))));
        r.depth_zero = (vz == 0);
        if (vz == 0) n_zero++;
        expected_screen.push_back(r);
    endfunction

    // Driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || took_in) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
                    i_item <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= !stall_active && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        took_in <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            project_word(i_item);
            if (i_item.cmd == CMD_PROJECT) n_points++; else n_loads++;
        end
    end

    // Hold off the receiver once asked
    initial begin
        wait (stall_go);
        stall_active = 1;
        repeat (300) @(posedge i_clk);
        stall_active = 0;
    end

    // Monitor
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_screen.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                errors++;
            end else begin
                e = expected_screen.pop_front();
                n_checked++;
                if (e.screen_x !== o_result.screen_x)
                    $display("%0t: screen_x exp %h got %h", $time, e.screen_x,
                             o_result.screen_x);
                if (e.screen_y !== o_result.screen_y)
                    $display("%0t: screen_y exp %h got %h", $time, e.screen_y,
                             o_result.screen_y);
                if (e.depth_zero !== o_result.depth_zero)
                    $display("%0t: depth_zero exp %b got %b", $time, e.depth_zero,
                             o_result.depth_zero);
                if (e !== o_result) errors++;
            end
        end
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(7))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return t_coord'($urandom_range(65536 * 4)) - t_coord'(65536 * 2);
            3: return 0;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_in_item load_word(int idx, t_coord v);
        t_in_item w;
        w = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
        w.cmd = CMD_LOAD;
        w.coeff_index = 4'(idx);
        w.coeff_value = v;
        return w;
    endfunction

    function automatic t_in_item point_word(t_coord x, t_coord y, t_coord z);
        t_in_item w;
        w = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
        w.cmd = CMD_PROJECT;
        w.point_x = x;
        w.point_y = y;
        w.point_z = z;
        return w;
    endfunction

    task automatic drain();
        int guard;
        guard = 0;
        while ((pending_words.size() > 0 || i_in_valid || expected_screen.size() > 0)
               && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, t_coord v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_CENTER_X) cx = 64'(v);
        else if (idx == REG_CENTER_Y) cy = 64'(v);
        else if (idx == REG_SCREEN_GAIN) gain = 64'(v);
    endtask

    task automatic random_batch(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) < 2)
                pending_words.push_back(load_word($urandom_range(15), rand_coord()));
            else
                pending_words.push_back(point_word(rand_coord(), rand_coord(),
                                                   rand_coord()));
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_COEFFS; i++) mat[i] = 0;
        mat[0] = 65536; mat[5] = 65536; mat[10] = 65536;
        cx = 0; cy = 0; gain = 65536;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 33; recv_idle = 84;

        // Directed: identity matrix, zero depth, extremes, ignored index
        pending_words.push_back(point_word(65536, 65536, 65536));
        pending_words.push_back(point_word(65536, -65536, 0));
        pending_words.push_back(point_word(-65536, 65536, 0));
        pending_words.push_back(point_word(0, 0, 0));
        pending_words.push_back(point_word(COORD_MAX, COORD_MIN, 1));
        pending_words.push_back(point_word(COORD_MIN, COORD_MAX, -1));
        pending_words.push_back(point_word(COORD_MAX, COORD_MAX, COORD_MAX));
        pending_words.push_back(load_word(13, 12345));
        pending_words.push_back(load_word(15, COORD_MIN));
        pending_words.push_back(load_word(3, COORD_MAX));
        pending_words.push_back(load_word(7, COORD_MIN));
        pending_words.push_back(load_word(11, 65536 * 5));
        pending_words.push_back(point_word(65536, 65536, 65536));
        pending_words.push_back(load_word(0, COORD_MAX));
        pending_words.push_back(load_word(1, COORD_MIN));
        pending_words.push_back(point_word(COORD_MAX, COORD_MIN, 0));
        pending_words.push_back(load_word(11, 0));
        pending_words.push_back(load_word(10, 0));
        pending_words.push_back(point_word(1, 1, 1));
        drain();

        write_reg(REG_CENTER_X, COORD_MAX);
        write_reg(REG_CENTER_Y, COORD_MIN);
        write_reg(REG_SCREEN_GAIN, COORD_MAX);
        write_reg(2'd3, 777);
        random_batch(400);
        drain();

        send_idle = 84; recv_idle = 33;
        write_reg(REG_CENTER_X, COORD_MIN);
        write_reg(REG_CENTER_Y, COORD_MAX);
        write_reg(REG_SCREEN_GAIN, COORD_MIN);
        random_batch(400);
        drain();

        // Long receiver hold-off with the sender streaming
        send_idle = 0; recv_idle = 0;
        write_reg(REG_CENTER_X, 320 * 65536);
        write_reg(REG_CENTER_Y, 240 * 65536);
        write_reg(REG_SCREEN_GAIN, 400 * 65536);
        stall_go = 1;
        random_batch(400);
        drain();

        $display("Projected %0d points (%0d zero depth), %0d coefficient loads, %0d checked.",
                 n_points, n_zero, n_loads, n_checked);
        if (errors == 0 && expected_screen.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
